FILE: rtl/core/pmt_pkg.sv
`default_nettype none
package pmt_pkg;

   localparam int ENTRIES = 256;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam logic [63:0] PAGE_BYTES = 64'd4096;

   typedef enum logic [1:0] {
      CMD_MAP   = 2'd0,
      CMD_UNMAP = 2'd1,
      CMD_P2V   = 2'd2,
      CMD_V2P   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP,
      ST_U_NEXT,
      ST_U_CHECK,
      ST_U_CMP,
      ST_U_SWAP,
      ST_L_CHECK,
      ST_L_CMP,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic map_write;
      logic step_page;
      logic miss_inc;
      logic j_clear;
      logic j_inc;
      logic rd_j;
      logic rd_last;
      logic swap_write;
      logic set_full;
      logic set_lkp_miss;
      logic set_hit;
      logic rsp_load;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic page_done;
      logic table_full;
      logic j_end;
      logic match;
      logic rsp_busy;
   } stat_type;

endpackage
`default_nettype wire

FILE: rtl/core/page_mapping_table.sv
// channel  ports            fields, lowest bit first
// -------  ---------------  ---------------------------------------------------
// request  req_t*           tuser: command; tdata: phys_addr, virt_addr, page_count
// response rsp_t*           tdata: addr_out, status, pages_missed, entries_used
//
// one request at a time; a beat is taken only while the controller is idle
// map: one table write per page, until the table is full; unmap: per page, a
// linear search over the single read port of the table memory, then a swap on
// a hit; lookup: a linear search; each request adds an accept and a result load
// synchronous reset empties the table at once (entry count to zero)
// a result waits while rsp_tready is low; the next request runs, then stalls
`default_nettype none
module page_mapping_table (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [143:0] req_tdata,  // phys_addr[63:0], virt_addr[127:64],
                                         // page_count[136:128], zero fill
   input  wire logic [1:0]   req_tuser,  // command[1:0]
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [87:0]       rsp_tdata   // addr_out[63:0], status[65:64],
                                         // pages_missed[74:66],
                                         // entries_used[83:75], zero fill
);

   // command and status between the sequencer and the table datapath
   pmt_pkg::ctrl_type ctrl;
   pmt_pkg::stat_type stat;

   // sequencer: page loop, search loop, swap and result hand-off
   pmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   // table memories, address stepping, counters and the result register
   pmt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctrl       (ctrl),
      .stat       (stat)
   );

endmodule
`default_nettype wire

FILE: rtl/core/pmt_ctrl.sv
`default_nettype none
module pmt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic [1:0]        req_tuser,
   output logic                   req_tready,
   input  wire pmt_pkg::stat_type stat,
   output pmt_pkg::ctrl_type      ctrl
);

   pmt_pkg::state_type state_ff, state_in;
   pmt_pkg::cmd_type   req_cmd;
   logic               accept;

   assign req_cmd    = pmt_pkg::cmd_type'(req_tuser);
   assign req_tready = (state_ff == pmt_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pmt_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  pmt_pkg::CMD_MAP:   state_in = pmt_pkg::ST_MAP;
                  pmt_pkg::CMD_UNMAP: state_in = pmt_pkg::ST_U_NEXT;
                  default:            state_in = pmt_pkg::ST_L_CHECK;
               endcase
            end
         end
         pmt_pkg::ST_MAP: begin
            if (stat.page_done || stat.table_full) begin
               state_in = pmt_pkg::ST_DONE;
            end
         end
         pmt_pkg::ST_U_NEXT: begin
            if (stat.page_done) begin
               state_in = pmt_pkg::ST_DONE;
            end else begin
               state_in = pmt_pkg::ST_U_CHECK;
            end
         end
         pmt_pkg::ST_U_CHECK: begin
            if (stat.j_end) begin
               state_in = pmt_pkg::ST_U_NEXT;
            end else begin
               state_in = pmt_pkg::ST_U_CMP;
            end
         end
         pmt_pkg::ST_U_CMP: begin
            if (stat.match) begin
               state_in = pmt_pkg::ST_U_SWAP;
            end else begin
               state_in = pmt_pkg::ST_U_CHECK;
            end
         end
         pmt_pkg::ST_U_SWAP: state_in = pmt_pkg::ST_U_NEXT;
         pmt_pkg::ST_L_CHECK: begin
            if (stat.j_end) begin
               state_in = pmt_pkg::ST_DONE;
            end else begin
               state_in = pmt_pkg::ST_L_CMP;
            end
         end
         pmt_pkg::ST_L_CMP: begin
            if (stat.match) begin
               state_in = pmt_pkg::ST_DONE;
            end else begin
               state_in = pmt_pkg::ST_L_CHECK;
            end
         end
         pmt_pkg::ST_DONE: begin
            if (!stat.rsp_busy) begin
               state_in = pmt_pkg::ST_IDLE;
            end
         end
         default: state_in = pmt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         pmt_pkg::ST_IDLE: ctrl.load = accept;
         pmt_pkg::ST_MAP: begin
            if (!stat.page_done) begin
               if (stat.table_full) begin
                  ctrl.set_full = 1'b1;
               end else begin
                  ctrl.map_write = 1'b1;
                  ctrl.step_page = 1'b1;
               end
            end
         end
         pmt_pkg::ST_U_NEXT: ctrl.j_clear = 1'b1;
         pmt_pkg::ST_U_CHECK: begin
            if (stat.j_end) begin
               ctrl.miss_inc  = 1'b1;
               ctrl.step_page = 1'b1;
            end else begin
               ctrl.rd_j = 1'b1;
            end
         end
         pmt_pkg::ST_U_CMP: begin
            if (stat.match) begin
               ctrl.rd_last = 1'b1;
            end else begin
               ctrl.j_inc = 1'b1;
            end
         end
         pmt_pkg::ST_U_SWAP: begin
            ctrl.swap_write = 1'b1;
            ctrl.step_page  = 1'b1;
         end
         pmt_pkg::ST_L_CHECK: begin
            if (stat.j_end) begin
               ctrl.set_lkp_miss = 1'b1;
            end else begin
               ctrl.rd_j = 1'b1;
            end
         end
         pmt_pkg::ST_L_CMP: begin
            if (stat.match) begin
               ctrl.set_hit = 1'b1;
            end else begin
               ctrl.j_inc = 1'b1;
            end
         end
         pmt_pkg::ST_DONE: ctrl.rsp_load = !stat.rsp_busy;
         default: ctrl = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/core/pmt_datapath.sv
`default_nettype none
module pmt_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        req_tuser,
   input  wire logic [143:0]      req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [87:0]            rsp_tdata,
   input  wire pmt_pkg::ctrl_type ctrl,
   output pmt_pkg::stat_type      stat
);

   localparam int IW = pmt_pkg::IDX_W;
   localparam int CW = pmt_pkg::CNT_W;

   logic [63:0] phys_mem [pmt_pkg::ENTRIES];
   logic [63:0] virt_mem [pmt_pkg::ENTRIES];

   logic [63:0]         rd_phys_ff, rd_virt_ff;
   pmt_pkg::cmd_type    cmd_ff;
   logic [63:0]         p_ff, v_ff, addr_ff;
   logic [8:0]          n_ff, i_ff, missed_ff;
   logic [CW-1:0]       count_ff, j_ff;
   pmt_pkg::status_type status_ff;

   logic                rsp_valid_ff;
   logic [87:0]         rsp_data_ff;

   logic [IW-1:0]       rd_addr, wr_addr, last_idx;
   logic                rd_en, wr_en;
   logic [63:0]         wr_phys, wr_virt;
   logic                match;

   assign last_idx = IW'(count_ff - CW'(1));
   assign rd_en    = ctrl.rd_j || ctrl.rd_last;
   assign rd_addr  = ctrl.rd_last ? last_idx : j_ff[IW-1:0];
   assign wr_en    = ctrl.map_write || ctrl.swap_write;
   assign wr_addr  = ctrl.swap_write ? j_ff[IW-1:0] : count_ff[IW-1:0];
   assign wr_phys  = ctrl.swap_write ? rd_phys_ff : p_ff;
   assign wr_virt  = ctrl.swap_write ? rd_virt_ff : v_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         phys_mem[wr_addr] <= wr_phys;
         virt_mem[wr_addr] <= wr_virt;
      end
      if (rd_en) begin
         rd_phys_ff <= phys_mem[rd_addr];
         rd_virt_ff <= virt_mem[rd_addr];
      end
   end

   always_comb begin
      case (cmd_ff)
         pmt_pkg::CMD_P2V: match = (rd_phys_ff == p_ff);
         pmt_pkg::CMD_V2P: match = (rd_virt_ff == v_ff);
         default:          match = (rd_phys_ff == p_ff) && (rd_virt_ff == v_ff);
      endcase
   end

   assign stat.page_done  = (i_ff == n_ff);
   assign stat.table_full = (count_ff >= CW'(pmt_pkg::ENTRIES));
   assign stat.j_end      = (j_ff >= count_ff);
   assign stat.match      = match;
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;

   // operation registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff    <= pmt_pkg::cmd_type'(req_tuser);
         p_ff      <= req_tdata[63:0];
         v_ff      <= req_tdata[127:64];
         n_ff      <= req_tdata[136:128];
         i_ff      <= '0;
         j_ff      <= '0;
         missed_ff <= '0;
         addr_ff   <= '0;
         status_ff <= pmt_pkg::STATUS_OK;
      end else begin
         if (ctrl.step_page) begin
            p_ff <= p_ff + pmt_pkg::PAGE_BYTES;
            v_ff <= v_ff + pmt_pkg::PAGE_BYTES;
            i_ff <= i_ff + 9'd1;
         end
         if (ctrl.j_clear) begin
            j_ff <= '0;
         end else if (ctrl.j_inc) begin
            j_ff <= j_ff + CW'(1);
         end
         if (ctrl.miss_inc || ctrl.set_lkp_miss) begin
            status_ff <= pmt_pkg::STATUS_MISS;
         end
         if (ctrl.miss_inc) begin
            missed_ff <= missed_ff + 9'd1;
         end
         if (ctrl.set_full) begin
            status_ff <= pmt_pkg::STATUS_FULL;
            missed_ff <= n_ff - i_ff;
         end
         if (ctrl.set_hit) begin
            addr_ff <= (cmd_ff == pmt_pkg::CMD_P2V) ? rd_virt_ff : rd_phys_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.map_write) begin
         count_ff <= count_ff + CW'(1);
      end else if (ctrl.swap_write) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_data_ff <= {4'd0, 9'(count_ff), missed_ff, status_ff, addr_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: test/page_mapping_table_tb.sv
`default_nettype none
module page_mapping_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmt_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS   = 600;
   localparam int HOLD_CYCLES    = 1500;       // long receiver hold-off
   localparam int DRAIN_CYCLES   = 64;         // quiet time after the last response
   // slowest request: a 511-page unmap on a full table, plus the hold-off;
   // taken several times over
   localparam int WATCHDOG_LIMIT = 1_000_000;

   // address pools, chosen so that random ranges overlap and collide
   localparam logic [63:0] PHYS_BASE = 64'h0000_0000_8000_0000;
   localparam logic [63:0] VIRT_BASE = 64'hFFFF_8000_0000_0000;
   localparam logic [63:0] WRAP_BASE = 64'hFFFF_FFFF_FFFC_0000;
   localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [63:0] addr;
      status_type  status;
      logic [8:0]  missed;
      logic [8:0]  used;
   } table_outcome_type;

   typedef struct {
      cmd_type           cmd;
      logic [63:0]       phys;
      logic [63:0]       virt;
      logic [8:0]        count;
      bit                typed;      // outcome written into the row by hand
      table_outcome_type want;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;   // phys_addr[63:0], virt_addr[127:64], page_count[136:128]
   logic [1:0]   req_tuser;   // command[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;   // addr_out[63:0], status[65:64], pages_missed[74:66],
                              // entries_used[83:75]

   // shadow copy of the translation table
   logic [63:0]  mirror_phys [ENTRIES];
   logic [63:0]  mirror_virt [ENTRIES];
   int           mirror_count = 0;
   int           peak_entries = 0;

   table_outcome_type pending_outcomes [$];
   dir_row_type       directed_rows [$];
   table_outcome_type blank_outcome = '{addr: '0, status: STATUS_OK, missed: '0, used: '0};
   table_outcome_type head;

   int  mismatches    = 0;
   int  checked       = 0;
   int  accepted      = 0;
   int  full_seen     = 0;
   int  miss_seen     = 0;
   int  stall_cycles  = 0;
   int  hold_requests = 0;     // bumped by the sender, served by the receiver
   bit  quiet         = 1'b0;  // no idling on either side while set

   page_mapping_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected outcome of one request, applied to the shadow table
   function automatic table_outcome_type table_op_outcome(cmd_type cmd, logic [63:0] p,
                                                          logic [63:0] v, logic [8:0] n);
      table_outcome_type o;
      int missed;
      bit hit;
      o.addr   = '0;
      o.status = STATUS_OK;
      o.missed = '0;
      case (cmd)
         CMD_MAP: begin
            // append pairs until the range is done or the table is full
            for (int i = 0; i < int'(n); i++) begin
               if (mirror_count >= ENTRIES) begin
                  o.status = STATUS_FULL;
                  o.missed = 9'(int'(n) - i);
                  break;
               end
               mirror_phys[mirror_count] = p;
               mirror_virt[mirror_count] = v;
               mirror_count++;
               p += PAGE_BYTES;
               v += PAGE_BYTES;
            end
         end
         CMD_UNMAP: begin
            missed = 0;
            for (int i = 0; i < int'(n); i++) begin
               hit = 1'b0;
               // first exact pair match, filled from the last entry
               for (int j = 0; j < mirror_count; j++) begin
                  if (mirror_phys[j] == p && mirror_virt[j] == v) begin
                     mirror_phys[j] = mirror_phys[mirror_count - 1];
                     mirror_virt[j] = mirror_virt[mirror_count - 1];
                     mirror_count--;
                     hit = 1'b1;
                     break;
                  end
               end
               if (!hit) missed++;
               // both addresses step whether the page was found or not
               p += PAGE_BYTES;
               v += PAGE_BYTES;
            end
            if (missed != 0) o.status = STATUS_MISS;
            o.missed = 9'(missed);
         end
         default: begin
            // lookups: lowest-indexed match wins
            hit = 1'b0;
            for (int j = 0; j < mirror_count; j++) begin
               if (cmd == CMD_P2V ? mirror_phys[j] == p : mirror_virt[j] == v) begin
                  o.addr = (cmd == CMD_P2V) ? mirror_virt[j] : mirror_phys[j];
                  hit = 1'b1;
                  break;
               end
            end
            if (!hit) o.status = STATUS_MISS;
         end
      endcase
      o.used = 9'(mirror_count);
      if (mirror_count > peak_entries) peak_entries = mirror_count;
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pool_page(logic [63:0] base);
      return base + 64'($urandom_range(63)) * PAGE_BYTES;
   endfunction

   task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("response %0d: %s is %0h, expected %0h", checked, field, got, want);
   endtask

   task automatic dir_row(cmd_type cmd, logic [63:0] p, logic [63:0] v, logic [8:0] n,
                          bit typed = 1'b0, logic [63:0] addr = '0,
                          status_type st = STATUS_OK, logic [8:0] miss = '0,
                          logic [8:0] used = '0);
      dir_row_type row;
      row.cmd         = cmd;
      row.phys        = p;
      row.virt        = v;
      row.count       = n;
      row.typed       = typed;
      row.want.addr   = addr;
      row.want.status = st;
      row.want.missed = miss;
      row.want.used   = used;
      directed_rows.push_back(row);
   endtask

   // offer one request beat and hold it until taken, then log its outcome
   task automatic offer_request(cmd_type cmd, logic [63:0] p, logic [63:0] v,
                                logic [8:0] n, bit typed, table_outcome_type want);
      table_outcome_type outcome;
      while (!quiet && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, n, v, p};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      outcome = table_op_outcome(cmd, p, v, n);
      pending_outcomes.push_back(typed ? want : outcome);
      accepted++;
   endtask

   // random request drawn against the current table contents
   task automatic pick_random_op(output cmd_type cmd, output logic [63:0] p,
                                 output logic [63:0] v, output logic [8:0] n);
      int r;
      int j;
      int map_pct;
      int unmap_pct;
      // steer the fill level: grow an empty table, drain a crowded one
      map_pct   = (mirror_count < 16) ? 60 : (mirror_count > 200) ? 10 : 30;
      unmap_pct = (mirror_count > 200) ? 50 : 25;
      r = $urandom_range(99);
      if (r < map_pct) begin
         cmd = CMD_MAP;
         r = $urandom_range(99);
         if (r < 1)      n = 9'($urandom_range(511, 256));   // fills the table
         else if (r < 4) n = '0;
         else if (r < 9) n = 9'($urandom_range(40, 9));
         else            n = 9'($urandom_range(8, 1));
         r = $urandom_range(99);
         if (r < 25) begin
            p = rand64();
            v = rand64();
         end else if (r < 35) begin
            // ranges near the top of the address space; some run past it
            p = pool_page(WRAP_BASE);
            v = pool_page(WRAP_BASE);
         end else begin
            p = pool_page(PHYS_BASE);
            v = pool_page(VIRT_BASE);
         end
      end else if (r < map_pct + unmap_pct) begin
         cmd = CMD_UNMAP;
         r = $urandom_range(99);
         n = (r < 3) ? 9'd0 : (r < 6) ? 9'($urandom_range(32, 7)) : 9'($urandom_range(6, 1));
         r = $urandom_range(99);
         if (mirror_count > 0 && r < 80) begin
            // start on a stored pair; a few get a broken virtual half
            j = $urandom_range(mirror_count - 1);
            p = mirror_phys[j];
            v = mirror_virt[j];
            if (r < 10) v += PAGE_BYTES;
         end else begin
            p = pool_page(PHYS_BASE);
            v = (r < 90) ? pool_page(VIRT_BASE) : rand64();
         end
      end else begin
         cmd = ($urandom_range(1) == 0) ? CMD_P2V : CMD_V2P;
         n = 9'($urandom_range(511));   // don't care for lookups
         p = rand64();
         v = rand64();
         r = $urandom_range(99);
         if (mirror_count > 0 && r < 70) begin
            j = $urandom_range(mirror_count - 1);
            p = mirror_phys[j];
            v = mirror_virt[j];
         end else if (mirror_count > 0 && r < 80) begin
            // one page off a stored key
            j = $urandom_range(mirror_count - 1);
            p = mirror_phys[j] + PAGE_BYTES;
            v = mirror_virt[j] + PAGE_BYTES;
         end else if (r < 90) begin
            p = pool_page(PHYS_BASE);
            v = pool_page(VIRT_BASE);
         end
      end
   endtask

   // receiver: random stalls, quiet stretches and one long hold-off
   int hold_left = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 20);
      end
   end

   // response checker: each beat against the oldest outcome
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked++;
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("unexpected beat, addr_out", rsp_tdata[63:0], '0);
         end else begin
            head = pending_outcomes.pop_front();
            if (rsp_tdata[63:0] !== head.addr)
               flag_mismatch("addr_out", rsp_tdata[63:0], head.addr);
            if (rsp_tdata[65:64] !== head.status)
               flag_mismatch("status", 64'(rsp_tdata[65:64]), 64'(head.status));
            if (rsp_tdata[74:66] !== head.missed)
               flag_mismatch("pages_missed", 64'(rsp_tdata[74:66]), 64'(head.missed));
            if (rsp_tdata[83:75] !== head.used)
               flag_mismatch("entries_used", 64'(rsp_tdata[83:75]), 64'(head.used));
            if (head.status == STATUS_FULL) full_seen++;
            if (head.status == STATUS_MISS) miss_seen++;
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles = stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, pending_outcomes.size());
            $display("page_mapping_table_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      cmd_type     cmd;
      logic [63:0] p;
      logic [63:0] v;
      logic [8:0]  n;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_MAP;
      req_tdata  = '0;

      // empty table: misses and zero-page requests, no entries used
      dir_row(CMD_P2V,   '0, '0, 9'd3, 1, '0, STATUS_MISS, 9'd0, 9'd0);
      dir_row(CMD_V2P,   ALL_ONES, ALL_ONES, 9'd0, 1, '0, STATUS_MISS, 9'd0, 9'd0);
      dir_row(CMD_UNMAP, '0, '0, 9'd3, 1, '0, STATUS_MISS, 9'd3, 9'd0);
      dir_row(CMD_MAP,   ALL_ONES, ALL_ONES, 9'd0, 1, '0, STATUS_OK, 9'd0, 9'd0);
      dir_row(CMD_UNMAP, ALL_ONES, ALL_ONES, 9'd0, 1, '0, STATUS_OK, 9'd0, 9'd0);
      // physical range wrapping past the top, virtual starting at zero
      dir_row(CMD_MAP,   64'hFFFF_FFFF_FFFF_F000, '0, 9'd2, 1, '0, STATUS_OK, 9'd0, 9'd2);
      dir_row(CMD_P2V,   '0, ALL_ONES, 9'd0, 1, 64'h1000, STATUS_OK, 9'd0, 9'd2);
      dir_row(CMD_V2P,   ALL_ONES, '0, 9'd0, 1, 64'hFFFF_FFFF_FFFF_F000, STATUS_OK,
              9'd0, 9'd2);
      // same physical page twice: lookup returns the older entry
      dir_row(CMD_MAP,   64'h1000_0000, 64'hAAAA_AAAA_AAAA_A000, 9'd1);
      dir_row(CMD_MAP,   64'h1000_0000, 64'h5555_5555_5555_5000, 9'd1);
      dir_row(CMD_P2V,   64'h1000_0000, '0, 9'd0);
      // duplicate exact pair: unmap removes only one of them
      dir_row(CMD_MAP,   64'h2000, 64'h3000, 9'd1);
      dir_row(CMD_MAP,   64'h2000, 64'h3000, 9'd1);
      dir_row(CMD_UNMAP, 64'h2000, 64'h3000, 9'd1);
      dir_row(CMD_P2V,   64'h2000, '0, 9'd0);
      // unmap over the wrap, last page absent
      dir_row(CMD_UNMAP, 64'hFFFF_FFFF_FFFF_F000, '0, 9'd3);
      // largest count fills the table, then a map on a full table
      dir_row(CMD_MAP,   ALL_ONES, ALL_ONES, 9'h1FF);
      dir_row(CMD_MAP,   64'h4000, 64'h5000, 9'd1, 1, '0, STATUS_FULL, 9'd1, 9'd256);
      dir_row(CMD_V2P,   '0, ALL_ONES, 9'd0);
      dir_row(CMD_P2V,   64'h1000_0000, '0, 9'd0);
      // largest unmap removes that range again, leaving the older entries
      dir_row(CMD_UNMAP, ALL_ONES, ALL_ONES, 9'h1FF);
      dir_row(CMD_P2V,   ALL_ONES, '0, 9'd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_request(directed_rows[i].cmd, directed_rows[i].phys, directed_rows[i].virt,
                       directed_rows[i].count, directed_rows[i].typed,
                       directed_rows[i].want);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         quiet = (k >= 250 && k < 360);
         // receiver backs off while requests keep coming
         if (k == 120) hold_requests++;
         // sender stops until every response is back
         if (k == 450) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_outcomes.size() != 0);
         end
         pick_random_op(cmd, p, v, n);
         offer_request(cmd, p, v, n, 1'b0, blank_outcome);
      end
      req_tvalid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random requests, %0d responses checked",
               directed_rows.size(), accepted - directed_rows.size(), checked);
      $display("table reached %0d of %0d entries; %0d full and %0d miss responses",
               peak_entries, ENTRIES, full_seen, miss_seen);
      if (mismatches == 0) begin
         $display("page_mapping_table_tb: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("page_mapping_table_tb: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
